FILE: design/assert_macros.svh
// Assertion macros shared by the trie sequence unit; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/tsil_pkg.sv
// Types and codes shared by the trie sequence insert and lookup unit.
package tsil_pkg;

    // Action codes of an input item.
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    // Status codes of a result item.
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // One input item: one symbol of a sequence.
    typedef struct packed {
        logic       action;
        logic [3:0] symbol;
        logic       last;
    } request_t;

    // One result item, given on the last symbol of a sequence.
    typedef struct packed {
        logic found;
        logic status;
    } response_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_write;
        logic accept;
        logic evaluate;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
    } ctrl_status_t;

endpackage

FILE: design/tsil_ctrl.sv
// Controller state machine: clearing pass, idle and evaluate states.
`include "assert_macros.svh"

module tsil_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  tsil_pkg::ctrl_status_t status,
    output tsil_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EVAL  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state: clear the table once, then alternate accept and evaluate.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Commands and the handshake output.
    assign busy            = (state_reg != ST_IDLE);
    assign cmd.clear_write = (state_reg == ST_CLEAR);
    assign cmd.accept      = (state_reg == ST_IDLE) && start;
    assign cmd.evaluate    = (state_reg == ST_EVAL);

    `ASSERT_NEXT(a_eval_follows_accept, clk, rst_n, cmd.accept, cmd.evaluate)
    `ASSERT_IMPLIES(a_no_accept_in_clear, clk, rst_n, cmd.clear_write, !cmd.accept && busy)
    `ASSERT_NEXT(a_clear_ends_idle, clk, rst_n, cmd.clear_write && status.clear_last, !busy)

endmodule

FILE: design/tsil_datapath.sv
// Datapath: child table memory, cursor, node count and result register.
`include "assert_macros.svh"

module tsil_datapath #(
    parameter int POOL_NODES = 1024,
    parameter int ALPHABET   = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tsil_pkg::request_t     request,
    input  tsil_pkg::ctrl_cmd_t    cmd,
    output tsil_pkg::ctrl_status_t status,
    output logic                   done,
    output tsil_pkg::response_t    response
);

    localparam int NODE_W  = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
    localparam int SYM_W   = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int ADDR_W  = NODE_W + SYM_W;
    localparam int DEPTH   = 1 << ADDR_W;
    localparam int ENTRY_W = NODE_W + 1;
    localparam int COUNT_W = NODE_W + 1;

    // Each entry holds the child node and, in its top bit, the terminal
    // mark of that child; every node but the root has one parent slot.
    logic [ENTRY_W-1:0] mem [DEPTH];

    tsil_pkg::request_t  item_reg;
    tsil_pkg::response_t response_reg;
    logic [ADDR_W-1:0]   slot_reg;
    logic [ENTRY_W-1:0]  rd_data_reg;
    logic [NODE_W-1:0]   cursor_reg;
    logic [NODE_W-1:0]   cursor_next;
    logic [COUNT_W-1:0]  nodes_used_reg;
    logic [COUNT_W-1:0]  nodes_used_next;
    logic                failed_reg;
    logic                failed_next;
    logic [ADDR_W-1:0]   clr_addr_reg;
    logic                done_reg;

    logic [ADDR_W-1:0]   rd_addr;
    logic [NODE_W-1:0]   child;
    logic                has_child;
    logic                child_term;
    logic                sym_bad;
    logic                pool_full;
    logic                is_lookup;
    logic                alloc;
    logic                walk_fail;
    logic [NODE_W-1:0]   walk_node;
    logic                eval_write;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0]  wr_data;

    // Slot of the cursor node and the incoming symbol.
    assign rd_addr = {cursor_reg, SYM_W'(request.symbol)};

    // One step of the walk, from the entry read at accept.
    assign child      = rd_data_reg[NODE_W-1:0];
    assign child_term = rd_data_reg[NODE_W];
    assign has_child  = (child != '0);
    assign sym_bad    = (int'(item_reg.symbol) >= ALPHABET);
    assign pool_full  = (nodes_used_reg >= COUNT_W'(POOL_NODES));
    assign is_lookup  = (item_reg.action == tsil_pkg::ACT_LOOKUP);
    assign walk_fail  = failed_reg || sym_bad ||
                        (!has_child && (is_lookup || pool_full));
    assign alloc      = !walk_fail && !has_child;
    assign walk_node  = has_child ? child : nodes_used_reg[NODE_W-1:0];

    // A new child is marked only on a last item; a final insert marks the reached node.
    assign eval_write = !walk_fail && !is_lookup && (alloc || item_reg.last);

    assign wr_en   = cmd.clear_write || (cmd.evaluate && eval_write);
    assign wr_addr = cmd.clear_write ? clr_addr_reg : slot_reg;
    assign wr_data = cmd.clear_write ? '0 : {item_reg.last, walk_node};

    // Table memory with a registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.accept)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Item capture.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= request;
            slot_reg <= rd_addr;
        end
    end

    // Walk state after the step; a last item returns to the root.
    always_comb
    begin
        cursor_next     = cursor_reg;
        failed_next     = failed_reg;
        nodes_used_next = nodes_used_reg;
        if (cmd.evaluate)
        begin
            if (alloc)
            begin
                nodes_used_next = nodes_used_reg + COUNT_W'(1);
            end
            if (item_reg.last)
            begin
                cursor_next = '0;
                failed_next = 1'b0;
            end
            else
            begin
                cursor_next = walk_fail ? cursor_reg : walk_node;
                failed_next = walk_fail;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg     <= '0;
            failed_reg     <= 1'b0;
            nodes_used_reg <= COUNT_W'(1);
            clr_addr_reg   <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            cursor_reg     <= cursor_next;
            failed_reg     <= failed_next;
            nodes_used_reg <= nodes_used_next;
            done_reg       <= cmd.evaluate && item_reg.last;
            if (cmd.clear_write)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
        end
    end

    // Result of a last item.
    always_ff @(posedge clk)
    begin
        if (cmd.evaluate && item_reg.last)
        begin
            response_reg.found  <= is_lookup && !walk_fail && child_term;
            response_reg.status <= (!is_lookup && walk_fail) ? tsil_pkg::STATUS_FULL
                                                             : tsil_pkg::STATUS_OK;
        end
    end

    assign status.clear_last = (clr_addr_reg == '1);
    assign done              = done_reg;
    assign response          = response_reg;

    `ASSERT_ALWAYS(a_count_in_pool, clk, rst_n,
        (nodes_used_reg <= COUNT_W'(POOL_NODES)) && (nodes_used_reg != '0))
    `ASSERT_ALWAYS(a_cursor_allocated, clk, rst_n, {1'b0, cursor_reg} < nodes_used_reg)
    `ASSERT_IMPLIES(a_done_after_eval, clk, rst_n, done_reg, $past(cmd.evaluate))

endmodule

FILE: design/trie_sequence_insert_lookup_unit.sv
// Top level of the trie sequence insert and lookup unit.
//
// Keeps a trie of symbol sequences in a pool of POOL_NODES nodes. An item is
// one symbol with its action (insert or lookup) and a last flag; it is
// accepted at a rising edge with start high and busy low. Only the last item
// of a sequence gives a result: response carries found and status, marked by
// done for exactly one cycle. The receiver cannot stall, so a result is
// simply taken in that cycle.
// Each item is handled in steps: the child table is read at the slot of the
// cursor node and symbol, then the item is evaluated and a new child or the
// terminal mark is written; the next symbol needs the updated cursor. For a
// last item, done is registered from the evaluate state and is high in the
// same cycle in which busy is low again, so the result is taken at the same
// edge at which the next item may already be accepted.
// The child table holds 2**(ceil(log2(POOL_NODES)) + ceil(log2(ALPHABET)))
// entries (16384 at the defaults). After reset it is cleared one entry a
// cycle; busy stays high until the pass ends.
module trie_sequence_insert_lookup_unit #(
    parameter int POOL_NODES = 1024,
    parameter int ALPHABET   = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  tsil_pkg::request_t  request,
    output logic                done,
    output tsil_pkg::response_t response
);

    tsil_pkg::ctrl_cmd_t    cmd;
    tsil_pkg::ctrl_status_t status;

    // Sequencing of the clearing pass and the two steps of an item.
    tsil_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    // Child table, walk state and result register.
    tsil_datapath #(
        .POOL_NODES (POOL_NODES),
        .ALPHABET   (ALPHABET)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .cmd      (cmd),
        .status   (status),
        .done     (done),
        .response (response)
    );

endmodule

FILE: bench/tb_trie_sequence_insert_lookup_unit.sv
// Self-checking testbench of the trie sequence insert and lookup unit.
`timescale 1ns / 100ps

module tb_trie_sequence_insert_lookup_unit;

    localparam int POOL_NODES  = 1024;
    localparam int ALPHABET    = 16;
    localparam int NODE_W      = $clog2(POOL_NODES);
    localparam int STALL_LIMIT = 100000;
    localparam int FILL_LENGTH = 12;

    // One row of the directed script.
    typedef struct {
        tsil_pkg::request_t  req;
        bit                  typed;
        tsil_pkg::response_t answer;
    } script_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    tsil_pkg::request_t  request = '0;
    logic                done;
    tsil_pkg::response_t response;

    // Trie state mirrored from the block.
    bit   [NODE_W-1:0] child_tbl [POOL_NODES*ALPHABET];
    bit                term_mark [POOL_NODES];
    logic [NODE_W:0]   nodes_used = 1;
    logic [NODE_W-1:0] cursor = '0;
    bit                seq_failed = 1'b0;

    tsil_pkg::response_t pending_answers [$];
    script_row_t         script [$];
    logic [63:0]         stored_syms [$];
    int                  stored_len [$];
    int                  symbols_sent = 0;
    int                  mismatch_count = 0;
    int                  stall_cycles = 0;

    trie_sequence_insert_lookup_unit #(
        .POOL_NODES(POOL_NODES),
        .ALPHABET  (ALPHABET)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .response(response)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Walk one symbol through the mirrored trie; returns 1 when it yields an answer.
    function automatic bit walk_symbol(input tsil_pkg::request_t r,
                                       output tsil_pkg::response_t ans);
        int unsigned       slot;
        logic [NODE_W-1:0] nxt;
        ans = '{found: 1'b0, status: tsil_pkg::STATUS_OK};
        if (!seq_failed)
        begin
            if (int'(r.symbol) >= ALPHABET)
                seq_failed = 1'b1;
            else
            begin
                slot = cursor * ALPHABET + r.symbol;
                nxt = child_tbl[slot];
                if (nxt != '0)
                    cursor = nxt;
                else if (r.action == tsil_pkg::ACT_LOOKUP)
                    seq_failed = 1'b1;
                else if (nodes_used < POOL_NODES)
                begin
                    child_tbl[slot] = nodes_used[NODE_W-1:0];
                    cursor = nodes_used[NODE_W-1:0];
                    nodes_used++;
                end
                else
                    seq_failed = 1'b1;
            end
        end
        if (!r.last)
            return 1'b0;
        if (r.action == tsil_pkg::ACT_LOOKUP)
            ans.found = !seq_failed && term_mark[cursor];
        else if (seq_failed)
            ans.status = tsil_pkg::STATUS_FULL;
        else
            term_mark[cursor] = 1'b1;
        cursor = '0;
        seq_failed = 1'b0;
        return 1'b1;
    endfunction

    // Present one item, wait for its acceptance and record the answer it owes.
    task automatic send_symbol(input tsil_pkg::request_t r, input bit typed,
                               input tsil_pkg::response_t typed_ans);
        tsil_pkg::response_t ans;
        bit                  quiet;
        quiet = symbols_sent >= 600 && symbols_sent < 900;
        if (!quiet && $urandom_range(0, 99) < 15)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        symbols_sent++;
        if (walk_symbol(r, ans))
            pending_answers.push_back(typed ? typed_ans : ans);
    endtask

    // Send a whole sequence; a mixed one draws the action of each inner item at random.
    task automatic send_sequence(input logic [63:0] syms, input int len, input bit mixed,
                                 input logic act);
        tsil_pkg::request_t r;
        for (int i = 0; i < len; i++)
        begin
            r.symbol = syms[4*i +: 4];
            r.last = (i == len - 1);
            r.action = (mixed && !r.last) ? logic'($urandom_range(0, 1)) : act;
            send_symbol(r, 1'b0, '0);
        end
    endtask

    // Hold the sender back until every answer owed has come.
    task automatic drain_answers();
        start <= 1'b0;
        @(posedge clk);
        while (pending_answers.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_row(input logic act, input logic [3:0] sym, input logic lst,
                           input bit typed, input logic fnd, input logic sts);
        script_row_t row;
        row.req = '{action: act, symbol: sym, last: lst};
        row.typed = typed;
        row.answer = '{found: fnd, status: sts};
        script.push_back(row);
    endtask

    // Random sequences: inserts, lookups of stored sequences and their neighbors, noise.
    task automatic random_mix(input int count);
        int          stop_at;
        int          pick;
        int          idx;
        int          len;
        logic [63:0] syms;
        stop_at = symbols_sent + count;
        while (symbols_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            syms = {$urandom, $urandom};
            len = $urandom_range(1, 6);
            if (stored_len.size() > 0 && pick < 75 && (pick >= 40 || pick < 10))
            begin
                idx = $urandom_range(0, stored_len.size() - 1);
                syms = stored_syms[idx];
                len = stored_len[idx];
            end
            if (pick < 40)
            begin
                send_sequence(syms, len, 1'b0, tsil_pkg::ACT_INSERT);
                stored_syms.push_back(syms);
                stored_len.push_back(len);
            end
            else if (pick < 75)
            begin
                // Now and then try a prefix or a one-symbol extension.
                case ($urandom_range(0, 5))
                    0:
                    begin
                        if (len > 1)
                            len--;
                    end
                    1:
                    begin
                        syms[4*len +: 4] = 4'($urandom);
                        len++;
                    end
                    default:
                    begin
                    end
                endcase
                send_sequence(syms, len, 1'b0, tsil_pkg::ACT_LOOKUP);
            end
            else if (pick < 88)
                send_sequence(syms, len, 1'b0, tsil_pkg::ACT_LOOKUP);
            else
                send_sequence(syms, len, 1'b1, logic'($urandom_range(0, 1)));
        end
    endtask

    // Each answer is taken in the cycle done is high and checked against the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_answers.size() == 0)
            begin
                $display("%0t: answer with none owed: found %0b status %0b",
                         $time, response.found, response.status);
                mismatch_count++;
            end
            else
            begin
                if (response.found !== pending_answers[0].found)
                begin
                    $display("%0t: found expected %0b actual %0b",
                             $time, pending_answers[0].found, response.found);
                    mismatch_count++;
                end
                if (response.status !== pending_answers[0].status)
                begin
                    $display("%0t: status expected %0b actual %0b",
                             $time, pending_answers[0].status, response.status);
                    mismatch_count++;
                end
                void'(pending_answers.pop_front());
            end
        end
    end

    // The run ends if nothing moves for too long; this covers the clearing pass after reset.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        logic [63:0] syms;

        // Empty trie, single symbols, extremes, prefixes, missing children, mixed actions.
        add_row(tsil_pkg::ACT_LOOKUP, 4'd5,  1'b1, 1'b1, 1'b0, tsil_pkg::STATUS_OK);
        add_row(tsil_pkg::ACT_INSERT, 4'd0,  1'b1, 1'b1, 1'b0, tsil_pkg::STATUS_OK);
        add_row(tsil_pkg::ACT_LOOKUP, 4'd0,  1'b1, 1'b1, 1'b1, tsil_pkg::STATUS_OK);
        add_row(tsil_pkg::ACT_INSERT, 4'd15, 1'b0, 1'b0, 1'b0, tsil_pkg::STATUS_OK);
        add_row(tsil_pkg::ACT_INSERT, 4'd15, 1'b0, 1'b0, 1'b0, tsil_pkg::STATUS_OK);
        add_row(tsil_pkg::ACT_INSERT, 4'd15, 1'b1, 1'b1, 1'b0, tsil_pkg::STATUS_OK);
        add_row(tsil_pkg::ACT_LOOKUP, 4'd15, 1'b0, 1'b0, 1'b0, tsil_pkg::STATUS_OK);
        add_row(tsil_pkg::ACT_LOOKUP, 4'd15, 1'b1, 1'b1, 1'b0, tsil_pkg::STATUS_OK);
        add_row(tsil_pkg::ACT_LOOKUP, 4'd15, 1'b0, 1'b0, 1'b0, tsil_pkg::STATUS_OK);
        add_row(tsil_pkg::ACT_LOOKUP, 4'd15, 1'b0, 1'b0, 1'b0, tsil_pkg::STATUS_OK);
        add_row(tsil_pkg::ACT_LOOKUP, 4'd15, 1'b1, 1'b1, 1'b1, tsil_pkg::STATUS_OK);
        add_row(tsil_pkg::ACT_LOOKUP, 4'd15, 1'b0, 1'b0, 1'b0, tsil_pkg::STATUS_OK);
        add_row(tsil_pkg::ACT_LOOKUP, 4'd15, 1'b0, 1'b0, 1'b0, tsil_pkg::STATUS_OK);
        add_row(tsil_pkg::ACT_LOOKUP, 4'd15, 1'b0, 1'b0, 1'b0, tsil_pkg::STATUS_OK);
        add_row(tsil_pkg::ACT_LOOKUP, 4'd0,  1'b1, 1'b1, 1'b0, tsil_pkg::STATUS_OK);
        add_row(tsil_pkg::ACT_INSERT, 4'd3,  1'b0, 1'b0, 1'b0, tsil_pkg::STATUS_OK);
        add_row(tsil_pkg::ACT_LOOKUP, 4'd10, 1'b1, 1'b0, 1'b0, tsil_pkg::STATUS_OK);
        add_row(tsil_pkg::ACT_LOOKUP, 4'd7,  1'b0, 1'b0, 1'b0, tsil_pkg::STATUS_OK);
        add_row(tsil_pkg::ACT_INSERT, 4'd1,  1'b1, 1'b1, 1'b0, tsil_pkg::STATUS_FULL);
        add_row(tsil_pkg::ACT_INSERT, 4'd3,  1'b1, 1'b0, 1'b0, tsil_pkg::STATUS_OK);
        add_row(tsil_pkg::ACT_LOOKUP, 4'd3,  1'b1, 1'b0, 1'b0, tsil_pkg::STATUS_OK);

        // Hold reset first; after its release the block clears its table while busy.
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
            send_symbol(script[i].req, script[i].typed, script[i].answer);
        drain_answers();

        random_mix(450);

        // Long fresh sequences until every node of the pool is in use.
        while (nodes_used < POOL_NODES)
        begin
            syms = {$urandom, $urandom};
            send_sequence(syms, FILL_LENGTH, 1'b0, tsil_pkg::ACT_INSERT);
            stored_syms.push_back(syms);
            stored_len.push_back(FILL_LENGTH);
        end
        drain_answers();

        // The pool is full: fresh inserts fail, known paths still work.
        repeat (16)
        begin
            syms = {$urandom, $urandom};
            send_sequence(syms, 4, 1'b0, tsil_pkg::ACT_INSERT);
        end
        random_mix(200);

        // Let the last answers come out, then give the verdict.
        drain_answers();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
